/* hw/rtl/slcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slcp_pkg;

	// Command bytes
	localparam logic [7:0] CMD_ADDR    = 8'h61;	// 'a'
	localparam logic [7:0] CMD_CNT     = 8'h63;	// 'c'
	localparam logic [7:0] CMD_DATA    = 8'h64;	// 'd'
	localparam logic [7:0] CMD_JUMP    = 8'h6A;	// 'j'
	localparam logic [7:0] CMD_PAD     = 8'h70;	// 'p'
	localparam logic [7:0] CMD_VERSION = 8'h76;	// 'v'
	localparam logic [7:0] ACK_CHAR    = 8'h66;	// 'f'

	// Version text, fixed
	localparam int TEXT_SIZE = 10;
	localparam int VER_IDX_W = $clog2(TEXT_SIZE);
	localparam logic [7:0] VERSION_TEXT [TEXT_SIZE] = '{
		8'h50, 8'h4C, 8'h50, 8'h45, 8'h4D, 8'h55, 8'h2D, 8'h35, 8'h2E, 8'h30
	};
	localparam int VERSION_LENGTH_DEF = 10;

	// Queue between parser and output stage
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ADDR,
		MODE_DATA,
		MODE_COUNT,
		MODE_BURST,
		MODE_SKIP,
		MODE_HALTED
	} mode_t;

	// One parsed action, handed from the parser to the output stage
	typedef struct packed {
		logic        write_valid;
		logic        reply_valid;
		logic        jump_valid;
		logic        is_version;
		logic [31:0] addr;
		logic [31:0] data;
	} entry_t;

endpackage

`default_nettype wire

/* hw/rtl/slcp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface slcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slcp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface slcp_out_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [31:0] write_address;
	logic [31:0] write_data;
	logic        reply_valid;
	logic [7:0]  reply_byte;
	logic        jump_valid;
	logic [31:0] entry_address;
	logic        last;

	modport source (output valid, input ready, output write_valid, output write_address,
		output write_data, output reply_valid, output reply_byte, output jump_valid,
		output entry_address, output last);
	modport sink (input valid, output ready, input write_valid, input write_address,
		input write_data, input reply_valid, input reply_byte, input jump_valid,
		input entry_address, input last);
endinterface

`default_nettype wire

/* hw/rtl/slcp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module slcp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	slcp_in_if.sink              in_ch,
	input  wire logic            q_full,
	output      logic            push,
	output      slcp_pkg::entry_t push_entry
);
	import slcp_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] word_q, word_d;
	logic [31:0] addr_q, addr_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] word_shift;
	logic        word_done;
	logic        fire;

	assign in_ch.ready = ~q_full;
	assign fire        = in_ch.valid & ~q_full;
	assign word_shift  = {word_q[23:0], in_ch.rx_byte};
	assign word_done   = (pos_q == 2'd3);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			word_q   <= '0;
			addr_q   <= '0;
			remain_q <= '0;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			word_q   <= word_d;
			addr_q   <= addr_d;
			remain_q <= remain_d;
		end
	end

	// Command decode and word gathering
	always_comb begin
		mode_d     = mode_q;
		pos_d      = pos_q;
		word_d     = word_q;
		addr_d     = addr_q;
		remain_d   = remain_q;
		push       = 1'b0;
		push_entry = '0;
		if (fire) begin
			unique case (mode_q)
				MODE_IDLE: begin
					pos_d = '0;
					unique case (in_ch.rx_byte)
						CMD_ADDR: mode_d = MODE_ADDR;
						CMD_DATA: mode_d = MODE_DATA;
						CMD_CNT:  mode_d = MODE_COUNT;
						CMD_PAD:  mode_d = MODE_SKIP;
						CMD_JUMP: begin
							mode_d                 = MODE_HALTED;
							push                   = 1'b1;
							push_entry.reply_valid = 1'b1;
							push_entry.jump_valid  = 1'b1;
							push_entry.addr        = addr_q;
						end
						CMD_VERSION: begin
							push                  = 1'b1;
							push_entry.is_version = 1'b1;
						end
						default: ;	// unknown command, dropped
					endcase
				end
				MODE_ADDR: begin
					pos_d  = pos_q + 2'd1;
					word_d = word_shift;
					if (word_done) begin
						addr_d                 = word_shift;
						mode_d                 = MODE_IDLE;
						push                   = 1'b1;
						push_entry.reply_valid = 1'b1;
					end
				end
				MODE_DATA: begin
					pos_d  = pos_q + 2'd1;
					word_d = word_shift;
					if (word_done) begin
						addr_d                 = addr_q + 32'd4;
						mode_d                 = MODE_IDLE;
						push                   = 1'b1;
						push_entry.write_valid = 1'b1;
						push_entry.reply_valid = 1'b1;
						push_entry.addr        = addr_q;
						push_entry.data        = word_shift;
					end
				end
				MODE_COUNT: begin
					pos_d  = pos_q + 2'd1;
					word_d = word_shift;
					if (word_done) begin
						remain_d = word_shift;
						if (word_shift == '0) begin
							// empty burst acks at once
							mode_d                 = MODE_IDLE;
							push                   = 1'b1;
							push_entry.reply_valid = 1'b1;
						end else begin
							mode_d = MODE_BURST;
						end
					end
				end
				MODE_BURST: begin
					pos_d  = pos_q + 2'd1;
					word_d = word_shift;
					if (word_done) begin
						remain_d               = remain_q - 32'd1;
						addr_d                 = addr_q + 32'd4;
						push                   = 1'b1;
						push_entry.write_valid = 1'b1;
						push_entry.addr        = addr_q;
						push_entry.data        = word_shift;
						// final word of the burst carries the ack
						if (remain_q == 32'd1) begin
							push_entry.reply_valid = 1'b1;
							mode_d                 = MODE_IDLE;
						end
					end
				end
				MODE_SKIP: begin
					pos_d  = pos_q + 2'd1;
					word_d = word_shift;
					if (word_done) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_HALTED: ;
				default: mode_d = MODE_HALTED;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/slcp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module slcp_queue #(
	parameter int DEPTH = slcp_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire slcp_pkg::entry_t push_entry,
	input  wire logic             pop,
	output      slcp_pkg::entry_t head,
	output      logic             empty,
	output      logic             full
);
	import slcp_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CntW'(DEPTH));
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/slcp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module slcp_back #(
	parameter int VERSION_LENGTH = slcp_pkg::VERSION_LENGTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slcp_pkg::entry_t head,
	input  wire logic             q_empty,
	output      logic             pop,
	slcp_out_if.source            out_ch
);
	import slcp_pkg::*;

	localparam int VersionCount = (VERSION_LENGTH > TEXT_SIZE) ? TEXT_SIZE : VERSION_LENGTH;

	logic                 out_valid_q;
	logic                 write_valid_q, reply_valid_q, jump_valid_q, last_q;
	logic [31:0]          write_address_q, write_data_q, entry_address_q;
	logic [7:0]           reply_byte_q;
	logic [VER_IDX_W-1:0] ver_idx_q;
	logic                 can_load, load, last_char;

	assign can_load  = ~out_valid_q | out_ch.ready;
	assign load      = can_load & ~q_empty;
	assign last_char = (ver_idx_q == VER_IDX_W'(VersionCount - 1));
	// a version entry leaves the queue with its final character
	assign pop       = load & (~head.is_version | last_char);

	// Output register control and version character counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ver_idx_q   <= '0;
		end else begin
			if (can_load) begin
				out_valid_q <= ~q_empty;
			end
			if (load && head.is_version) begin
				ver_idx_q <= last_char ? '0 : ver_idx_q + 1'b1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			write_valid_q   <= head.write_valid;
			write_address_q <= head.write_valid ? head.addr : '0;
			write_data_q    <= head.data;
			reply_valid_q   <= head.reply_valid | head.is_version;
			jump_valid_q    <= head.jump_valid;
			entry_address_q <= head.jump_valid ? head.addr : '0;
			last_q          <= ~head.is_version | last_char;
			if (head.is_version) begin
				reply_byte_q <= VERSION_TEXT[ver_idx_q];
			end else begin
				reply_byte_q <= head.reply_valid ? ACK_CHAR : 8'h00;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.write_valid   = write_valid_q;
	assign out_ch.write_address = write_address_q;
	assign out_ch.write_data    = write_data_q;
	assign out_ch.reply_valid   = reply_valid_q;
	assign out_ch.reply_byte    = reply_byte_q;
	assign out_ch.jump_valid    = jump_valid_q;
	assign out_ch.entry_address = entry_address_q;
	assign out_ch.last          = last_q;

endmodule

`default_nettype wire

/* hw/rtl/serial_loader_command_parser.sv */
// Each result passes through the action queue and then the output register.
// Throughput: one byte per cycle; a 'v' command holds the output register
// for its min(VERSION_LENGTH, 10) characters, and the four-entry action
// queue absorbs input meanwhile. Input stalls only when that queue is full.
// Reset (arst_n low, asynchronous): parser idle, load address zero, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_loader_command_parser #(
	parameter int VERSION_LENGTH = slcp_pkg::VERSION_LENGTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slcp_in_if.sink    in_ch,
	slcp_out_if.source out_ch
);
	import slcp_pkg::*;

	entry_t push_entry, head;
	logic   push, pop, q_empty, q_full;

	// Byte parser
	slcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Action queue
	slcp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Result generation
	slcp_back #(
		.VERSION_LENGTH (VERSION_LENGTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);

	// Nothing can appear at the output without a queued action behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_ch.valid && q_empty) |=> !out_ch.valid)
		else $error("result shown with empty queue");

	// Only version characters are followed by more results of the same byte
	a_multi_only_version: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.last) |->
			(out_ch.reply_valid && !out_ch.write_valid && !out_ch.jump_valid))
		else $error("non-final result that is not a version character");

	// A jump carries the ack and ends its byte
	a_jump_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.jump_valid) |->
			(out_ch.reply_valid && out_ch.last && !out_ch.write_valid &&
			 out_ch.reply_byte == ACK_CHAR))
		else $error("malformed jump result");

endmodule

`default_nettype wire
